FILE: rtl/core/bhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
`default_nettype none

package bhq_pkg;

    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int STATUS_BITS  = 2;
    localparam int COUNT_BITS   = 7;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [1:0] OP_PUSH       = 2'd0;
    localparam logic [1:0] OP_POP        = 2'd1;
    localparam logic [1:0] OP_PUSH_FULL  = 2'd2;
    localparam logic [1:0] OP_POP_EMPTY  = 2'd3;

    typedef struct packed {
        logic                    func;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [KEY_BITS-1:0]     out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic [STATUS_BITS-1:0]  status;
        logic [COUNT_BITS-1:0]   entry_count;
        logic                    is_empty;
    } t_out_item;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic [1:0]              op;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_ch;

endpackage

`default_nettype wire

FILE: rtl/core/bhq_front.sv
// Front end: accepts items, classifies them against the fill count and queues commands.
`default_nettype none

module bhq_front #(
    parameter int DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire bhq_pkg::t_in_item i_item,
    output bhq_pkg::t_cmd_ch       o_cmd,
    input  wire logic              i_take
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int QD = 2;
    localparam int QW = $clog2(QD);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    bhq_pkg::t_cmd   r_q [QD];
    bhq_pkg::t_cmd   w_cmd;
    logic [QW-1:0]   r_wp;
    logic [QW-1:0]   r_rp;
    logic [QW:0]     r_num;
    logic            accept;
    logic            take;

    assign o_full = (r_num == (QW+1)'(QD));
    assign accept = i_push && !o_full;
    assign take   = i_take && (r_num != '0);

    assign o_cmd.valid = (r_num != '0);
    assign o_cmd.cmd   = r_q[r_rp];

    always_comb begin
        n_count       = r_count;
        w_cmd.key     = i_item.key;
        w_cmd.payload = i_item.payload;
        if (i_item.func == bhq_pkg::FUNC_PUSH) begin
            if (r_count == CW'(DEPTH)) begin
                w_cmd.op = bhq_pkg::OP_PUSH_FULL;
            end else begin
                w_cmd.op = bhq_pkg::OP_PUSH;
                n_count  = r_count + CW'(1);
            end
        end else begin
            if (r_count == '0) begin
                w_cmd.op = bhq_pkg::OP_POP_EMPTY;
            end else begin
                w_cmd.op = bhq_pkg::OP_POP;
                n_count  = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_num   <= '0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_wp    <= r_wp + QW'(1);
            end
            if (take) begin
                r_rp <= r_rp + QW'(1);
            end
            r_num <= r_num + (QW+1)'(accept) - (QW+1)'(take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bhq_back.sv
// Back end: heap memory, sift sequencer and result register.
`default_nettype none

module bhq_back #(
    parameter int DEPTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bhq_pkg::t_cmd_ch i_cmd,
    output logic                  o_take,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output bhq_pkg::t_out_item    o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;
    localparam int OW = bhq_pkg::COUNT_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROOT = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    bhq_pkg::t_entry    r_mem [DEPTH];
    bhq_pkg::t_entry    r_rd_a;
    bhq_pkg::t_entry    r_rd_b;
    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      n_pos;
    logic               r_down;
    logic               n_down;
    bhq_pkg::t_entry    r_item;
    bhq_pkg::t_entry    n_item;
    bhq_pkg::t_out_item r_res;
    bhq_pkg::t_out_item n_res;
    logic               r_out_valid;
    bhq_pkg::t_out_item r_out;

    logic               rd_en;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    bhq_pkg::t_entry    wr_data;
    logic               load_out;

    logic [AW-1:0]      pos_m1;
    logic [AW-1:0]      parent;
    logic [AW-1:0]      grand_m1;
    logic [XW-1:0]      left;
    logic [XW-1:0]      right;
    logic               l_ok;
    logic               r_ok;
    logic               go_l;
    logic               go_r;
    logic [AW-1:0]      best;
    logic [XW-1:0]      next_l;
    logic [CW-1:0]      cnt_last;

    assign pos_m1   = r_pos - AW'(1);
    assign parent   = pos_m1 >> 1;
    assign grand_m1 = parent - AW'(1);
    assign left     = {1'b0, r_pos, 1'b1};
    assign right    = left + XW'(1);
    assign l_ok     = (left < XW'(r_count));
    assign r_ok     = (right < XW'(r_count));
    assign go_l     = l_ok && (r_rd_a.key < r_item.key);
    assign go_r     = r_ok && (r_rd_b.key < (go_l ? r_rd_a.key : r_item.key));
    assign best     = go_r ? right[AW-1:0] : left[AW-1:0];
    assign next_l   = {1'b0, best, 1'b1};
    assign cnt_last = r_count - CW'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_down    = r_down;
        n_item    = r_item;
        n_res     = r_res;
        rd_en     = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_item;
        o_take    = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    o_take         = 1'b1;
                    n_item.key     = i_cmd.cmd.key;
                    n_item.payload = i_cmd.cmd.payload;
                    n_res          = '0;
                    case (i_cmd.cmd.op)
                        bhq_pkg::OP_PUSH: begin
                            n_count      = r_count + CW'(1);
                            n_pos        = r_count[AW-1:0];
                            n_down       = 1'b0;
                            rd_en        = 1'b1;
                            rd_addr_a    = (r_count[AW-1:0] - AW'(1)) >> 1;
                            n_res.status = bhq_pkg::STATUS_OK;
                            n_state      = S_CMP;
                        end
                        bhq_pkg::OP_POP: begin
                            n_count      = cnt_last;
                            n_pos        = '0;
                            n_down       = 1'b1;
                            rd_en        = 1'b1;
                            rd_addr_a    = '0;
                            rd_addr_b    = cnt_last[AW-1:0];
                            n_res.status = bhq_pkg::STATUS_OK;
                            n_state      = S_ROOT;
                        end
                        bhq_pkg::OP_PUSH_FULL: begin
                            n_res.status = bhq_pkg::STATUS_FULL;
                            n_state      = S_DONE;
                        end
                        default: begin
                            n_res.status = bhq_pkg::STATUS_EMPTY;
                            n_state      = S_DONE;
                        end
                    endcase
                    n_res.entry_count = OW'(n_count);
                    n_res.is_empty    = (n_count == '0);
                end
            end
            S_ROOT: begin
                n_res.out_key     = r_rd_a.key;
                n_res.out_payload = r_rd_a.payload;
                n_item            = r_rd_b;
                rd_en             = 1'b1;
                rd_addr_a         = left[AW-1:0];
                rd_addr_b         = right[AW-1:0];
                n_state           = S_CMP;
            end
            S_CMP: begin
                if (r_down) begin
                    if (go_l || go_r) begin
                        wr_en     = 1'b1;
                        wr_data   = go_r ? r_rd_b : r_rd_a;
                        n_pos     = best;
                        rd_en     = 1'b1;
                        rd_addr_a = next_l[AW-1:0];
                        rd_addr_b = next_l[AW-1:0] + AW'(1);
                    end else begin
                        wr_en   = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    if ((r_pos != '0) && (r_rd_a.key > r_item.key)) begin
                        wr_en     = 1'b1;
                        wr_data   = r_rd_a;
                        n_pos     = parent;
                        rd_en     = 1'b1;
                        rd_addr_a = grand_m1 >> 1;
                    end else begin
                        wr_en   = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_pop) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_down <= n_down;
        r_item <= n_item;
        r_res  <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("heap fill count exceeds capacity");

    a_pos_in_heap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_count != '0) |-> (XW'(r_pos) < XW'(r_count)))
        else $error("sift position lies outside the occupied heap");

    a_result_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_pop) |=> (r_state == S_DONE))
        else $error("result left before the output register was free");

    a_out_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(i_pop))
        else $error("result discarded without a transfer");

endmodule

`default_nettype wire

FILE: rtl/core/binary_min_heap_queue_core.sv
// Top level of the binary min-heap queue: classifying front end, command queue and heap back end.
// A push runs from the command queue through S_IDLE, S_CMP and S_DONE into the result register,
// a pop through S_ROOT as well; a push makes at most log2(DEPTH) swaps, a pop log2(DEPTH) - 1.
// A dropped push or a pop on an empty heap goes from S_IDLE to S_DONE; a result waits while the
// last is untaken. The back end takes a new command only in S_IDLE, and sifts one level per cycle.
// Synchronous active-low reset empties heap, command queue and output; memory is not cleared.
`default_nettype none

module binary_min_heap_queue_core #(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire bhq_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output bhq_pkg::t_out_item      o_result
);

    bhq_pkg::t_cmd_ch cmd_ch;
    logic             cmd_take;

    bhq_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .i_item (i_item),
        .o_cmd  (cmd_ch),
        .i_take (cmd_take)
    );

    bhq_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_take  (cmd_take),
        .o_empty (empty),
        .i_pop   (pop),
        .o_result(o_result)
    );

endmodule

`default_nettype wire
